// ===== design/positional_array_list_top_defines.svh =====
// assertion macros for the checker file
`ifndef POSITIONAL_ARRAY_LIST_TOP_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define PAL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pal checker: same-cycle property failed");

// next-cycle implication, sampled on the rising clock edge
`define PAL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pal checker: next-cycle property failed");

`endif

// ===== design/pal_pkg.sv =====
`timescale 1ns / 1ps

package pal_pkg;

   // list geometry
   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int POS_W    = 7;
   localparam int VAL_W    = 32;
   localparam logic [POS_W-1:0] CAP_LEN = POS_W'(CAPACITY);

   // operation codes
   localparam logic [2:0] OP_GET    = 3'd0;
   localparam logic [2:0] OP_LOCATE = 3'd1;
   localparam logic [2:0] OP_INSERT = 3'd2;
   localparam logic [2:0] OP_DELETE = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   typedef struct packed {
      logic [2:0]              operation;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } pal_req_type;

   typedef struct packed {
      logic                    ok;
      logic signed [VAL_W-1:0] result_value;
      logic [POS_W-1:0]        found_position;
      logic [POS_W-1:0]        count;
      logic                    is_empty;
   } pal_rsp_type;

   // one write port and one read port of the element store
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [VAL_W-1:0]  wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } pal_mem_req_type;

endpackage

// ===== design/pal_mem.sv =====
`timescale 1ns / 1ps

module pal_mem (
   input  logic                        clock,
   input  pal_pkg::pal_mem_req_type    mem_req,
   output logic [pal_pkg::VAL_W-1:0]   rd_data
);
   import pal_pkg::*;

   logic [VAL_W-1:0] store_ff [CAPACITY];
   logic [VAL_W-1:0] rd_data_ff;

   // element store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= store_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/pal_seq.sv =====
`timescale 1ns / 1ps

module pal_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  pal_pkg::pal_req_type        req_data,
   output logic                        rsp_valid,
   output pal_pkg::pal_rsp_type        rsp_data,
   output pal_pkg::pal_mem_req_type    mem_req,
   input  logic [pal_pkg::VAL_W-1:0]   rd_data
);
   import pal_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD0  = 3'd1;
   localparam logic [2:0] S_RD1  = 3'd2;
   localparam logic [2:0] S_LOC  = 3'd3;
   localparam logic [2:0] S_INS  = 3'd4;
   localparam logic [2:0] S_DEL  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [POS_W-1:0]  len_ff, len_in;
   logic [2:0]        op_ff, op_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [POS_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [VAL_W-1:0]  rv_ff, rv_in;
   logic              rsp_valid_ff;
   pal_rsp_type       rsp_ff, rsp_in;

   logic              do_rsp;
   logic              rsp_ok;
   logic [VAL_W-1:0]  rsp_rv;
   logic [POS_W-1:0]  rsp_found;
   logic [POS_W-1:0]  pos_m1;
   logic [POS_W:0]    len_p1;
   logic              pos_in_list;

   assign busy     = (state_ff != S_IDLE);
   assign pos_m1   = pos_ff - 1'b1;
   assign len_p1   = {1'b0, len_ff} + 1'b1;
   assign pos_in_list = (req_data.position != '0) && (req_data.position <= len_ff);

   // sequencer: decode, walk the store, build the result item
   always_comb begin
      state_in   = state_ff;
      len_in     = len_ff;
      op_in      = op_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      idx_in     = idx_ff;
      pend_in    = pend_ff;
      wr_addr_in = wr_addr_ff;
      rv_in      = rv_ff;
      do_rsp     = 1'b0;
      rsp_ok     = 1'b0;
      rsp_rv     = '0;
      rsp_found  = '0;
      mem_req    = '0;

      // pending shift write carries the word read in the previous cycle
      mem_req.wr_en   = pend_ff;
      mem_req.wr_addr = wr_addr_ff;
      mem_req.wr_data = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_data.operation;
               pos_in = req_data.position;
               val_in = req_data.value;
               idx_in = '0;
               pend_in = 1'b0;
               case (req_data.operation)
                  OP_GET, OP_DELETE: begin
                     if (pos_in_list) begin
                        state_in = S_RD0;
                     end else begin
                        do_rsp = 1'b1;
                     end
                  end
                  OP_LOCATE: begin
                     state_in = S_LOC;
                  end
                  OP_INSERT: begin
                     if ((len_ff < CAP_LEN) && (req_data.position != '0) &&
                         ({1'b0, req_data.position} <= len_p1)) begin
                        idx_in   = len_ff;
                        state_in = S_INS;
                     end else begin
                        do_rsp = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     len_in = '0;
                     rsp_ok = 1'b1;
                     do_rsp = 1'b1;
                  end
                  default: begin
                     do_rsp = 1'b1;
                  end
               endcase
            end
         end
         // read the addressed entry
         S_RD0: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = pos_m1[ADDR_W-1:0];
            state_in        = S_RD1;
         end
         S_RD1: begin
            rv_in = rd_data;
            if (op_ff == OP_GET) begin
               rsp_ok   = 1'b1;
               rsp_rv   = rd_data;
               do_rsp   = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in   = pos_ff;
               pend_in  = 1'b0;
               state_in = S_DEL;
            end
         end
         // locate: read one entry a cycle, compare the one read before
         S_LOC: begin
            pend_in = 1'b0;
            if (pend_ff && (rd_data == val_ff)) begin
               rsp_ok    = 1'b1;
               rsp_found = {1'b0, wr_addr_ff} + 1'b1;
               do_rsp    = 1'b1;
               state_in  = S_IDLE;
            end else if (idx_ff == len_ff) begin
               do_rsp   = 1'b1;
               state_in = S_IDLE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff[ADDR_W-1:0];
               pend_in         = 1'b1;
               wr_addr_in      = idx_ff[ADDR_W-1:0];
               idx_in          = idx_ff + 1'b1;
            end
            // compare pipeline only, nothing is written
            mem_req.wr_en = 1'b0;
         end
         // insert: move entries up from the top, then drop the value in
         S_INS: begin
            if (idx_ff != pos_m1) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = pos_m1[ADDR_W-1:0] + (idx_ff[ADDR_W-1:0] - pos_ff[ADDR_W-1:0]);
               pend_in         = 1'b1;
               wr_addr_in      = idx_ff[ADDR_W-1:0];
               idx_in          = idx_ff - 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pos_m1[ADDR_W-1:0];
               mem_req.wr_data = val_ff;
               len_in          = len_ff + 1'b1;
               rsp_ok          = 1'b1;
               do_rsp          = 1'b1;
               state_in        = S_IDLE;
            end
         end
         // delete: move entries down from the hole to the top
         S_DEL: begin
            if (idx_ff != len_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff[ADDR_W-1:0];
               pend_in         = 1'b1;
               wr_addr_in      = idx_ff[ADDR_W-1:0] - 1'b1;
               idx_in          = idx_ff + 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               len_in   = len_ff - 1'b1;
               rsp_ok   = 1'b1;
               rsp_rv   = rv_ff;
               do_rsp   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.ok             = rsp_ok;
      rsp_in.result_value   = rsp_rv;
      rsp_in.found_position = rsp_found;
      rsp_in.count          = len_in;
      rsp_in.is_empty       = (len_in == '0);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= do_rsp;
      end
   end

   // item payload and walk registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      idx_ff     <= idx_in;
      wr_addr_ff <= wr_addr_in;
      rv_ff      <= rv_in;
      if (do_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/positional_array_list_top.sv =====
`timescale 1ns / 1ps

// channel   ports                          direction  transfer
// request   start, busy, req_data          in         start high while busy low
// response  rsp_valid, rsp_data            out        one-cycle strobe, no backpressure
//
// clear, failed and unknown requests answer in the cycle after acceptance.
// get reads the addressed entry; locate scans the entries from the front until
// a match or the end of the list; insert moves the entries from the position
// up by one, top first, then writes the value; delete moves the entries above
// the hole down by one. the store has one write port and a registered read.
// reset clears the length and control; store contents stay undefined until written.
// the receiver cannot stall: each result is shown for exactly one cycle.

module positional_array_list_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pal_pkg::pal_req_type  req_data,
   output logic                  rsp_valid,
   output pal_pkg::pal_rsp_type  rsp_data
);
   import pal_pkg::*;

   pal_mem_req_type  mem_req;
   logic [VAL_W-1:0] rd_data;

   // sequencer and length count
   pal_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   // element store
   pal_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

// ===== design/pal_checker.sv =====
`timescale 1ns / 1ps
`include "positional_array_list_top_defines.svh"

module pal_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input pal_pkg::pal_rsp_type  rsp_data
);
   import pal_pkg::*;

   logic found_in_list;

   // a reported position must be a successful one inside the list
   assign found_in_list = rsp_data.ok && (rsp_data.found_position <= rsp_data.count);

   // an accepted item is either being worked or answered next cycle
   `PAL_ASSERT_NEXT(a_accept_progress, start && !busy, busy || rsp_valid)

   // empty flag agrees with the reported length
   `PAL_ASSERT_NOW(a_empty_flag, rsp_valid, rsp_data.is_empty == (rsp_data.count == '0))

   // length never exceeds the store
   `PAL_ASSERT_NOW(a_count_range, rsp_valid, rsp_data.count <= CAP_LEN)

   // a found position lies inside the list and marks success
   `PAL_ASSERT_NOW(a_found_ok, rsp_valid && rsp_data.found_position != '0, found_in_list)

   // a failed item carries no element
   `PAL_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp_data.ok, rsp_data.result_value == '0)

endmodule

bind positional_array_list_top pal_checker u_pal_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
